// ===== src/cwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwl_pkg
// Shared types, token codes and keyword tables of the command word lexer.
// ----------------------------------------------------------------------------
package cwl_pkg;

    localparam int MAX_STEM_LEN_DEF  = 8;
    localparam int EXT_LEN_DEF       = 3;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CHAR_BITS   = 8;
    localparam int KIND_BITS   = 4;
    localparam int START_BITS  = 16;
    localparam int LENGTH_BITS = 8;

    localparam int KEY_COUNT   = 6;
    localparam int KEY_SLOTS   = 8;
    localparam int KEY_IDX_W   = $clog2(KEY_SLOTS);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LS       = 4'd0,
        KIND_CD       = 4'd1,
        KIND_CAT      = 4'd2,
        KIND_PRINT    = 4'd3,
        KIND_EXEC     = 4'd4,
        KIND_FILENAME = 4'd5,
        KIND_FOLDER   = 4'd6,
        KIND_ROOT     = 4'd7,
        KIND_UNKNOWN  = 4'd8
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [START_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0] length;
        logic                   done;
    } t_token;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    // Keyword spellings, zero padded: ls, cd, cat, print, exec, backslash.
    localparam logic [CHAR_BITS-1:0] KEY_CHARS [KEY_COUNT][KEY_SLOTS] = '{
        '{8'h6C, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h78, 8'h65, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [LENGTH_BITS-1:0] KEY_LENS [KEY_COUNT] = '{
        8'd2, 8'd2, 8'd3, 8'd5, 8'd4, 8'd1
    };

    localparam t_kind KEY_KINDS [KEY_COUNT] = '{
        KIND_LS, KIND_CD, KIND_CAT, KIND_PRINT, KIND_EXEC, KIND_ROOT
    };

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

// ===== src/cwl_word_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwl_word_tracker
// Per-byte word state and token classification for one accepted transfer per cycle.
// ----------------------------------------------------------------------------
module cwl_word_tracker import cwl_pkg::*; #(
    parameter int MAX_STEM_LEN  = MAX_STEM_LEN_DEF,
    parameter int EXT_LEN       = EXT_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [CHAR_BITS-1:0] i_char,
    input  logic                 i_last,
    output logic                 o_token_valid,
    output t_token               o_token
);

    localparam int STEM_W = $clog2(MAX_STEM_LEN + 1);
    localparam int EXT_W  = $clog2(EXT_LEN + 1);

    logic [POSITION_BITS-1:0] r_pos,     n_pos;
    logic                     r_inside,  n_inside;
    logic [POSITION_BITS-1:0] r_start,   n_start;
    logic [LENGTH_BITS-1:0]   r_len,     n_len;
    logic [STEM_W-1:0]        r_stem,    n_stem;
    logic                     r_dot,     n_dot;
    logic [EXT_W-1:0]         r_ext,     n_ext;
    logic                     r_ok,      n_ok;
    logic [KEY_COUNT-1:0]     r_cand,    n_cand;

    // Word state once the current byte has been taken in.
    logic [POSITION_BITS-1:0] w_start;
    logic [LENGTH_BITS-1:0]   w_len;
    logic [STEM_W-1:0]        w_stem;
    logic                     w_dot;
    logic [EXT_W-1:0]         w_ext;
    logic                     w_ok;
    logic [KEY_COUNT-1:0]     w_cand;
    logic [START_BITS-1:0]    w_start_sat;
    logic                     space;
    t_kind                    kind;

    assign space = is_space(i_char);

    always_comb begin
        w_start = r_inside ? r_start : r_pos;
        w_len   = r_len;
        w_stem  = r_stem;
        w_dot   = r_dot;
        w_ext   = r_ext;
        w_ok    = r_ok;
        w_cand  = r_cand;
        if (!space) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (r_len >= KEY_LENS[k] ||
                    KEY_CHARS[k][r_len[KEY_IDX_W-1:0]] != i_char) begin
                    w_cand[k] = 1'b0;
                end
            end
            if (is_alnum(i_char)) begin
                if (!r_dot) begin
                    if (r_stem >= STEM_W'(MAX_STEM_LEN)) begin
                        w_ok = 1'b0;
                    end else begin
                        w_stem = r_stem + STEM_W'(1);
                    end
                end else begin
                    if (r_ext >= EXT_W'(EXT_LEN)) begin
                        w_ok = 1'b0;
                    end else begin
                        w_ext = r_ext + EXT_W'(1);
                    end
                end
            end else if (i_char == CHAR_DOT) begin
                if (r_dot || r_stem == '0) begin
                    w_ok = 1'b0;
                end else begin
                    w_dot = 1'b1;
                end
            end else begin
                w_ok = 1'b0;
            end
            if (r_len != '1) begin
                w_len = r_len + LENGTH_BITS'(1);
            end
        end
    end

    generate
        if (POSITION_BITS > START_BITS) begin : g_start_sat
            assign w_start_sat = (|w_start[POSITION_BITS-1:START_BITS]) ?
                                 '1 : w_start[START_BITS-1:0];
        end else begin : g_start_ext
            assign w_start_sat = START_BITS'(w_start);
        end
    endgenerate

    always_comb begin
        kind = KIND_UNKNOWN;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (w_cand[k] && w_len == KEY_LENS[k]) begin
                kind = KEY_KINDS[k];
            end
        end
        if (kind == KIND_UNKNOWN && w_ok) begin
            if (w_dot && w_ext == EXT_W'(EXT_LEN)) begin
                kind = KIND_FILENAME;
            end else if (!w_dot && w_stem != '0) begin
                kind = KIND_FOLDER;
            end
        end
    end

    assign o_token_valid  = i_accept && (space ? r_inside : i_last);
    assign o_token.kind   = kind;
    assign o_token.start  = w_start_sat;
    assign o_token.length = w_len;
    assign o_token.done   = i_last;

    always_comb begin
        n_pos    = r_pos;
        n_inside = r_inside;
        n_start  = r_start;
        n_len    = r_len;
        n_stem   = r_stem;
        n_dot    = r_dot;
        n_ext    = r_ext;
        n_ok     = r_ok;
        n_cand   = r_cand;
        if (i_accept) begin
            if (i_last || space) begin
                n_inside = 1'b0;
                n_start  = '0;
                n_len    = '0;
                n_stem   = '0;
                n_dot    = 1'b0;
                n_ext    = '0;
                n_ok     = 1'b1;
                n_cand   = '1;
            end else begin
                n_inside = 1'b1;
                n_start  = w_start;
                n_len    = w_len;
                n_stem   = w_stem;
                n_dot    = w_dot;
                n_ext    = w_ext;
                n_ok     = w_ok;
                n_cand   = w_cand;
            end
            if (i_last) begin
                n_pos = '0;
            end else if (r_pos != '1) begin
                n_pos = r_pos + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_inside <= 1'b0;
            r_start  <= '0;
            r_len    <= '0;
            r_stem   <= '0;
            r_dot    <= 1'b0;
            r_ext    <= '0;
            r_ok     <= 1'b1;
            r_cand   <= '1;
        end else begin
            r_pos    <= n_pos;
            r_inside <= n_inside;
            r_start  <= n_start;
            r_len    <= n_len;
            r_stem   <= n_stem;
            r_dot    <= n_dot;
            r_ext    <= n_ext;
            r_ok     <= n_ok;
            r_cand   <= n_cand;
        end
    end

endmodule

// ===== src/command_word_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_word_lexer
// Splits a byte stream of commands into words and gives one token per word.
// ----------------------------------------------------------------------------
// The lexer takes one byte per clock cycle while s_axis_tready is high and
// registers each word's token when it accepts the byte that ends it: the
// whitespace byte after the word, or the word's own last byte when tlast
// ends the command. A two-entry output register keeps input transfers
// flowing while one token waits on a stalled output; input stalls only
// when both entries hold tokens.
module command_word_lexer import cwl_pkg::*; #(
    parameter int MAX_STEM_LEN  = MAX_STEM_LEN_DEF,
    parameter int EXT_LEN       = EXT_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] word_start, [23:16] word_length
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast
);

    logic   accept;
    logic   tok_valid;
    t_token tok;
    logic   out_pop;

    logic   r_out_valid,  n_out_valid;
    logic   r_skid_valid, n_skid_valid;
    t_token r_out,        n_out;
    t_token r_skid,       n_skid;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;

    cwl_word_tracker #(
        .MAX_STEM_LEN  (MAX_STEM_LEN),
        .EXT_LEN       (EXT_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_token_valid (tok_valid),
        .o_token       (tok)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_pop) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid && !n_out_valid) begin
            n_out        = r_skid;
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end
        if (tok_valid) begin
            if (!n_out_valid) begin
                n_out       = tok;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = tok;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.length, r_out.start};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.done;

endmodule

// ===== src/cwl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwl_checker
// Port-level assertions on the command word lexer, bound to its top level.
// ----------------------------------------------------------------------------
module cwl_checker import cwl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
        $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled token changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no token pending");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:16] != 8'd0 && m_axis_tuser <= KIND_UNKNOWN)
        else $error("token with empty word or bad kind");

    a_root_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ROOT |-> m_axis_tdata[23:16] == 8'd1)
        else $error("root token longer than one byte");

    a_short_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_LS || m_axis_tuser == KIND_CD)
        |-> m_axis_tdata[23:16] == 8'd2)
        else $error("two-letter keyword with wrong length");

endmodule

bind command_word_lexer cwl_checker u_cwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
